@@ sv/gmsst_pkg.sv @@
// ----------------------------------------------------------------------------
// gmsst_pkg: shared types and constants for the grid spread-time block
// Cell codes, configuration register indexes, the level counter format and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gmsst_pkg;

	// Cell codes as loaded from the stream
	localparam logic [1:0] CELL_EMPTY  = 2'd0;
	localparam logic [1:0] CELL_TARGET = 2'd1;
	localparam logic [1:0] CELL_SOURCE = 2'd2;

	// Configuration register indexes
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	// Configuration and result field widths
	localparam int CFG_W = 7;
	localparam int LVL_W = 12;
	localparam logic [LVL_W-1:0] LEVEL_MAX = {LVL_W{1'b1}};

	// Neighbor visiting order for one frontier entry
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} nb_dir_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_wr;
		logic load_last;
		logic setup;
		logic scan_step;
		logic lvl_mark;
		logic lvl_inc;
		logic fetch;
		logic nb_issue;
		logic nb_adv;
		logic nb_eval;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic head_at_end;
		logic queue_empty;
		logic nb_ok;
		logic nb_last;
		logic out_busy;
	} dp_sts_t;

endpackage

@@ sv/grid_multi_source_spread_time.sv @@
// ----------------------------------------------------------------------------
// grid_multi_source_spread_time: multi-source grid spread time
// Loads a grid one cell per transaction, then runs a level-by-level
// breadth-first spread from all sources and reports the level count or
// an unreachable flag.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                               | Transaction
//  --------+---------------------------------------+---------------------------
//  in      | in_valid, in_ready, cell_value,       | one grid cell, row-major
//          | last_cell                             |
//  out     | out_valid, out_ready, spread_minutes, | one result per grid
//          | unreachable                           |
//  cfg     | cfg_we, cfg_index, cfg_data           | size register write
//
//  Loading takes one cell per cycle while in_ready is high. After the last cell in_ready
//  stays low through the setup step and the source scan, then per queue entry a dispatch
//  and a fetch step plus a check and, if in range, a read for each of its four neighbors,
//  a step to close each level and a finish step; the single grid read port sets this pace.
//  No clearing pass after reset: only cells of the current grid are read.
//  A waiting result lets the next grid load but holds its finish cycle.
//
module grid_multi_source_spread_time #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gmsst_pkg::CFG_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cell_value,
	input  logic                        last_cell,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gmsst_pkg::LVL_W-1:0] spread_minutes,
	output logic                        unreachable
);
	import gmsst_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing controller
	gmsst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_cell (last_cell),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and arithmetic
	gmsst_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cell_value     (cell_value),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.spread_minutes (spread_minutes),
		.unreachable    (unreachable)
	);

endmodule

@@ sv/gmsst_ctrl.sv @@
// ----------------------------------------------------------------------------
// gmsst_ctrl: sequencing controller
// Steps through loading, source scan, level-by-level frontier expansion and
// result hand-off, issuing one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module gmsst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last_cell,
	input  gmsst_pkg::dp_sts_t sts,
	output gmsst_pkg::dp_cmd_t cmd
);
	import gmsst_pkg::*;

	typedef enum logic [7:0] {
		ST_LOAD   = 8'b0000_0001,
		ST_SETUP  = 8'b0000_0010,
		ST_SCAN   = 8'b0000_0100,
		ST_LEVEL  = 8'b0000_1000,
		ST_FETCH  = 8'b0001_0000,
		ST_NB_CHK = 8'b0010_0000,
		ST_NB_EVL = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_acc;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					cmd.load_wr = 1'b1;
					if (last_cell) begin
						cmd.load_last = 1'b1;
						state_d       = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					cmd.lvl_mark = 1'b1;
					state_d      = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				if (!sts.head_at_end) begin
					state_d = ST_FETCH;
				end else if (!sts.queue_empty) begin
					cmd.lvl_mark = 1'b1;
					cmd.lvl_inc  = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_NB_CHK;
			end
			ST_NB_CHK: begin
				if (sts.nb_ok) begin
					cmd.nb_issue = 1'b1;
					state_d      = ST_NB_EVL;
				end else if (sts.nb_last) begin
					state_d = ST_LEVEL;
				end else begin
					cmd.nb_adv = 1'b1;
				end
			end
			ST_NB_EVL: begin
				cmd.nb_eval = 1'b1;
				if (sts.nb_last) begin
					state_d = ST_LEVEL;
				end else begin
					cmd.nb_adv = 1'b1;
					state_d    = ST_NB_CHK;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/gmsst_dp.sv @@
// ----------------------------------------------------------------------------
// gmsst_dp: grid store, frontier queue and counters
// Holds the size registers, the grid memory, the frontier queue memory,
// scan and neighbor address generation and the result register.
// ----------------------------------------------------------------------------
module gmsst_dp #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [gmsst_pkg::CFG_W-1:0]   cfg_data,
	input  logic [1:0]                    cell_value,
	input  gmsst_pkg::dp_cmd_t            cmd,
	output gmsst_pkg::dp_sts_t            sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gmsst_pkg::LVL_W-1:0]   spread_minutes,
	output logic                          unreachable
);
	import gmsst_pkg::*;

	localparam int CAP    = MAX_ROWS * MAX_COLUMNS;
	localparam int CAP_W  = $clog2(CAP + 1);
	localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int CW     = $clog2(MAX_COLUMNS + 1);
	localparam int QW     = ADDR_W + RW + CW;
	localparam logic [CAP_W-1:0] CAP_CNT = CAP_W'(CAP);

	// Size registers
	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] column_count_q;
	logic [RW-1:0]    rows_clamp;
	logic [CW-1:0]    cols_clamp;
	logic [RW-1:0]    rows_q;
	logic [CW-1:0]    cols_q;
	logic [CAP_W-1:0] total;
	logic [CAP_W-1:0] loaded_q;

	// Counters
	logic [CAP_W-1:0] load_pos_q;
	logic [CAP_W-1:0] head_q;
	logic [CAP_W-1:0] tail_q;
	logic [CAP_W-1:0] level_end_q;
	logic [CAP_W-1:0] targets_q;
	logic [CAP_W-1:0] reached_q;
	logic [LVL_W-1:0] level_q;

	// Scan pipeline
	logic [CAP_W-1:0]  scan_p_q;
	logic [RW-1:0]     scan_r_q;
	logic [CW-1:0]     scan_c_q;
	logic              scan_issue;
	logic              scan_vld_s1;
	logic [ADDR_W-1:0] scan_pos_s1;
	logic [RW-1:0]     scan_r_s1;
	logic [CW-1:0]     scan_c_s1;

	// Memories and their ports
	logic [1:0]        grid_mem [CAP];
	logic [QW-1:0]     queue_mem [CAP];
	logic [1:0]        grid_rd_q;
	logic              grid_rd_en;
	logic [ADDR_W-1:0] grid_rd_addr;
	logic              grid_wr_en;
	logic [ADDR_W-1:0] grid_wr_addr;
	logic [1:0]        grid_wr_data;
	logic              q_wr_en;
	logic [QW-1:0]     q_wr_data;
	logic [QW-1:0]     q_rd_q;

	// Neighbor generation
	nb_dir_t           nb_q;
	logic [ADDR_W-1:0] ent_pos;
	logic [RW-1:0]     ent_r;
	logic [CW-1:0]     ent_c;
	logic [CAP_W-1:0]  pos_ext;
	logic [CAP_W-1:0]  cols_ext;
	logic              nb_in;
	logic [CAP_W-1:0]  nb_npos;
	logic [RW-1:0]     nb_nr;
	logic [CW-1:0]     nb_nc;
	logic [ADDR_W-1:0] nb_pos_q;
	logic [RW-1:0]     nb_r_q;
	logic [CW-1:0]     nb_c_q;
	logic              nb_hit;
	logic              missed;

	// Result register
	logic              out_valid_q;
	logic [LVL_W-1:0]  minutes_q;
	logic              unreach_q;

	// Clamp sizes into the supported range
	always_comb begin
		if (row_count_q == '0) begin
			rows_clamp = RW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_clamp = RW'(MAX_ROWS);
		end else begin
			rows_clamp = RW'(row_count_q);
		end
		if (column_count_q == '0) begin
			cols_clamp = CW'(1);
		end else if (int'(column_count_q) > MAX_COLUMNS) begin
			cols_clamp = CW'(MAX_COLUMNS);
		end else begin
			cols_clamp = CW'(column_count_q);
		end
	end

	assign total = CAP_W'(rows_q) * CAP_W'(cols_q);

	// Split the fetched frontier entry
	assign ent_pos  = q_rd_q[QW-1 -: ADDR_W];
	assign ent_r    = q_rd_q[RW+CW-1 -: RW];
	assign ent_c    = q_rd_q[CW-1:0];
	assign pos_ext  = CAP_W'(ent_pos);
	assign cols_ext = CAP_W'(cols_q);

	// Bound check and address of the current neighbor
	always_comb begin
		nb_in   = 1'b0;
		nb_npos = pos_ext;
		nb_nr   = ent_r;
		nb_nc   = ent_c;
		unique case (nb_q)
			DIR_UP: begin
				nb_in   = (ent_r != '0);
				nb_npos = pos_ext - cols_ext;
				nb_nr   = ent_r - RW'(1);
			end
			DIR_DOWN: begin
				nb_in   = (ent_r != rows_q - RW'(1));
				nb_npos = pos_ext + cols_ext;
				nb_nr   = ent_r + RW'(1);
			end
			DIR_LEFT: begin
				nb_in   = (ent_c != '0);
				nb_npos = pos_ext - CAP_W'(1);
				nb_nc   = ent_c - CW'(1);
			end
			DIR_RIGHT: begin
				nb_in   = (ent_c != cols_q - CW'(1));
				nb_npos = pos_ext + CAP_W'(1);
				nb_nc   = ent_c + CW'(1);
			end
			default: begin
				nb_in = 1'b0;
			end
		endcase
	end

	assign scan_issue = cmd.scan_step && (scan_p_q < loaded_q);
	assign nb_hit     = cmd.nb_eval && (grid_rd_q == CELL_TARGET);
	assign missed     = (targets_q != reached_q);

	// Grid port selection
	always_comb begin
		grid_rd_en   = scan_issue || cmd.nb_issue;
		grid_rd_addr = cmd.nb_issue ? nb_npos[ADDR_W-1:0] : scan_p_q[ADDR_W-1:0];
		grid_wr_en   = (cmd.load_wr && (load_pos_q != CAP_CNT)) || nb_hit;
		grid_wr_addr = nb_hit ? nb_pos_q : load_pos_q[ADDR_W-1:0];
		grid_wr_data = nb_hit ? CELL_SOURCE : cell_value;
	end

	// Queue write selection
	always_comb begin
		q_wr_en   = nb_hit || (scan_vld_s1 && (grid_rd_q == CELL_SOURCE));
		q_wr_data = nb_hit ? {nb_pos_q, nb_r_q, nb_c_q}
		                   : {scan_pos_s1, scan_r_s1, scan_c_s1};
	end

	// Grid memory
	always_ff @(posedge clk) begin
		if (grid_wr_en) begin
			grid_mem[grid_wr_addr] <= grid_wr_data;
		end
		if (grid_rd_en) begin
			grid_rd_q <= grid_mem[grid_rd_addr];
		end
	end

	// Frontier queue memory
	always_ff @(posedge clk) begin
		if (q_wr_en) begin
			queue_mem[tail_q[ADDR_W-1:0]] <= q_wr_data;
		end
		if (cmd.fetch) begin
			q_rd_q <= queue_mem[head_q[ADDR_W-1:0]];
		end
	end

	// Payload holding registers
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			loaded_q <= (load_pos_q < total) ? load_pos_q : total;
		end
		if (scan_issue) begin
			scan_pos_s1 <= scan_p_q[ADDR_W-1:0];
			scan_r_s1   <= scan_r_q;
			scan_c_s1   <= scan_c_q;
		end
		if (cmd.nb_issue) begin
			nb_pos_q <= nb_npos[ADDR_W-1:0];
			nb_r_q   <= nb_nr;
			nb_c_q   <= nb_nc;
		end
		if (cmd.finish) begin
			minutes_q <= missed ? '0 : level_q;
			unreach_q <= missed;
		end
	end

	// Control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CFG_W'(64);
			column_count_q <= CFG_W'(64);
			rows_q         <= '0;
			cols_q         <= '0;
			load_pos_q     <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			level_end_q    <= '0;
			targets_q      <= '0;
			reached_q      <= '0;
			level_q        <= '0;
			scan_p_q       <= '0;
			scan_r_q       <= '0;
			scan_c_q       <= '0;
			scan_vld_s1    <= 1'b0;
			nb_q           <= DIR_UP;
			out_valid_q    <= 1'b0;
		end else begin
			// take configuration writes
			if (cfg_we && (cfg_index == REG_ROW_COUNT)) begin
				row_count_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == REG_COLUMN_COUNT)) begin
				column_count_q <= cfg_data;
			end

			// advance the load position, drop cells past capacity
			if (cmd.load_wr && (load_pos_q != CAP_CNT)) begin
				load_pos_q <= load_pos_q + CAP_W'(1);
			end
			if (cmd.load_last) begin
				rows_q <= rows_clamp;
				cols_q <= cols_clamp;
			end

			// restart the scan
			if (cmd.setup) begin
				scan_p_q    <= '0;
				scan_r_q    <= '0;
				scan_c_q    <= '0;
				scan_vld_s1 <= 1'b0;
			end

			// walk the stored cells in row-major order
			if (cmd.scan_step) begin
				scan_vld_s1 <= scan_issue;
				if (scan_issue) begin
					scan_p_q <= scan_p_q + CAP_W'(1);
					if (scan_c_q == cols_q - CW'(1)) begin
						scan_c_q <= '0;
						scan_r_q <= scan_r_q + RW'(1);
					end else begin
						scan_c_q <= scan_c_q + CW'(1);
					end
				end
			end
			if (scan_vld_s1 && (grid_rd_q == CELL_TARGET)) begin
				targets_q <= targets_q + CAP_W'(1);
			end

			// enqueue sources and newly reached cells
			if (q_wr_en) begin
				tail_q <= tail_q + CAP_W'(1);
			end
			if (nb_hit) begin
				reached_q <= reached_q + CAP_W'(1);
			end

			// close a level
			if (cmd.lvl_mark) begin
				level_end_q <= tail_q;
			end
			if (cmd.lvl_inc && (level_q != LEVEL_MAX)) begin
				level_q <= level_q + LVL_W'(1);
			end

			// pop a frontier entry and step through its neighbors
			if (cmd.fetch) begin
				head_q <= head_q + CAP_W'(1);
				nb_q   <= DIR_UP;
			end
			if (cmd.nb_adv) begin
				nb_q <= nb_dir_t'(nb_q + 2'd1);
			end

			// hand off the result
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				load_pos_q  <= '0;
				head_q      <= '0;
				tail_q      <= '0;
				level_q     <= '0;
				targets_q   <= '0;
				reached_q   <= '0;
			end
		end
	end

	// Status to the controller
	always_comb begin
		sts.scan_done   = !scan_vld_s1 && (scan_p_q == loaded_q);
		sts.head_at_end = (head_q == level_end_q);
		sts.queue_empty = (head_q == tail_q);
		sts.nb_ok       = nb_in && (nb_npos < loaded_q);
		sts.nb_last     = (nb_q == DIR_RIGHT);
		sts.out_busy    = out_valid_q;
	end

	assign out_valid      = out_valid_q;
	assign spread_minutes = minutes_q;
	assign unreachable    = unreach_q;

endmodule

@@ bench/spread_time_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spread_time_checker: result predictor and comparator for the spread block
// Tracks size register writes, mirrors the loaded grid cell by cell and,
// on each last cell, runs its own level-by-level spread to predict the
// result. Each output transaction is compared field by field against the
// oldest predicted result.
// ----------------------------------------------------------------------------
module spread_time_checker #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [gmsst_pkg::CFG_W-1:0] cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  cell_value,
	input  logic                        last_cell,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [gmsst_pkg::LVL_W-1:0] spread_minutes,
	input  logic                        unreachable,
	output int                          fail_count,
	output int                          open_results,
	output int                          results_checked,
	output int                          unreach_seen
);
	import gmsst_pkg::*;

	localparam int CAP = MAX_ROWS * MAX_COLUMNS;

	typedef struct packed {
		logic [LVL_W-1:0] minutes;
		logic             unreach;
	} spread_t;

	logic [1:0]       cell_mem [CAP];
	int               wave [CAP];
	int               load_pos;
	logic [CFG_W-1:0] row_reg;
	logic [CFG_W-1:0] col_reg;
	spread_t          pending_spreads [$];
	int               fails;
	int               checked;
	int               unreach_n;

	// Turn a reachable target into a source and queue it for the next level
	function automatic void claim(int p, int loaded, inout int tail);
		if (p < loaded && cell_mem[p] == CELL_TARGET) begin
			cell_mem[p] = CELL_SOURCE;
			if (tail < CAP) begin
				wave[tail] = p;
				tail++;
			end
		end
	endfunction

	// Spread from every source at once, one level per pass over the frontier
	function automatic spread_t predict_spread();
		int      rows;
		int      cols;
		int      loaded;
		int      head;
		int      tail;
		int      stop;
		int      pos;
		int      p;
		int      levels;
		logic    missed;
		spread_t res;
		rows = (row_reg == 0) ? 1 : ((row_reg > MAX_ROWS) ? MAX_ROWS : int'(row_reg));
		cols = (col_reg == 0) ? 1 : ((col_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(col_reg));
		loaded = (load_pos < rows * cols) ? load_pos : rows * cols;
		head = 0;
		tail = 0;
		levels = 0;
		missed = 1'b0;
		for (p = 0; p < loaded; p++) begin
			if (cell_mem[p] == CELL_SOURCE) begin
				wave[tail] = p;
				tail++;
			end
		end
		while (head < tail) begin
			stop = tail;
			while (head < stop) begin
				pos = wave[head];
				head++;
				if (pos >= cols) claim(pos - cols, loaded, tail);
				if (pos / cols + 1 < rows) claim(pos + cols, loaded, tail);
				if (pos % cols > 0) claim(pos - 1, loaded, tail);
				if (pos % cols + 1 < cols) claim(pos + 1, loaded, tail);
			end
			if (head < tail && levels < LEVEL_MAX) levels++;
		end
		for (p = 0; p < loaded; p++) begin
			if (cell_mem[p] == CELL_TARGET) missed = 1'b1;
		end
		res.unreach = missed;
		res.minutes = missed ? '0 : levels[LVL_W-1:0];
		return res;
	endfunction

	// Compare results, then mirror loads and register writes
	always @(posedge clk or negedge arst_n) begin
		spread_t want;
		if (!arst_n) begin
			row_reg = 7'd64;
			col_reg = 7'd64;
			load_pos = 0;
			pending_spreads.delete();
			fails = 0;
			checked = 0;
			unreach_n = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_spreads.size() == 0) begin
					fails++;
					$display("%0t: unexpected result: expected none, %s %0d %s %0b",
						$time, "actual minutes", spread_minutes,
						"unreachable", unreachable);
				end else begin
					want = pending_spreads.pop_front();
					checked++;
					if (want.unreach) unreach_n++;
					if (spread_minutes !== want.minutes) begin
						fails++;
						$display("%0t: spread_minutes mismatch: expected %0d, actual %0d",
							$time, want.minutes, spread_minutes);
					end
					if (unreachable !== want.unreach) begin
						fails++;
						$display("%0t: unreachable mismatch: expected %0b, actual %0b",
							$time, want.unreach, unreachable);
					end
				end
			end
			if (in_valid && in_ready) begin
				// drop cells past the store capacity
				if (load_pos < CAP) begin
					cell_mem[load_pos] = cell_value;
					load_pos++;
				end
				if (last_cell) begin
					pending_spreads.push_back(predict_spread());
					load_pos = 0;
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ROW_COUNT) row_reg = cfg_data;
				else col_reg = cfg_data;
			end
		end
		fail_count      <= fails;
		open_results    <= pending_spreads.size();
		results_checked <= checked;
		unreach_seen    <= unreach_n;
	end

endmodule

@@ bench/tb_grid_multi_source_spread_time.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_multi_source_spread_time: stimulus and verdict for the spread block
// Drives directed grids for sizes, cell codes and load corner cases, then
// random grids under several idle and stall mixes. The checker instance
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_grid_multi_source_spread_time;
	import gmsst_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_CELLS   = 1650;
	localparam int MAX_SIDE       = 64;
	localparam int MAX_RANDOM_AREA = 512;
	localparam logic [1:0] CELL_VOID = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_ROW_COUNT;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       cell_value = CELL_EMPTY;
	logic             last_cell = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [LVL_W-1:0] spread_minutes;
	logic             unreachable;

	int src_idle = 0;
	int sink_stall = 0;
	int cells_sent = 0;
	int grids_sent = 0;
	int quiet_cycles = 0;
	int fail_count;
	int open_results;
	int results_checked;
	int unreach_seen;

	grid_multi_source_spread_time uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cell_value    (cell_value),
		.last_cell     (last_cell),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.spread_minutes(spread_minutes),
		.unreachable   (unreachable)
	);

	spread_time_checker u_spread_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cell_value     (cell_value),
		.last_cell      (last_cell),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.spread_minutes (spread_minutes),
		.unreachable    (unreachable),
		.fail_count     (fail_count),
		.open_results   (open_results),
		.results_checked(results_checked),
		.unreach_seen   (unreach_seen)
	);

	always #HALF_PERIOD clk = ~clk;

	// Stall the result channel at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall);
	end

	// End the run if no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int eff_side(int v);
		return (v == 0) ? 1 : ((v > MAX_SIDE) ? MAX_SIDE : v);
	endfunction

	// Mostly small sides, some zero, oversize and wide values
	function automatic int pick_side();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8) return 0;
		if (roll < 16) return $urandom_range(127, 65);
		if (roll < 26) return $urandom_range(64, 9);
		return $urandom_range(8, 1);
	endfunction

	function automatic logic [1:0] pick_cell(int tgt_pct, int src_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < src_pct) return CELL_SOURCE;
		if (roll < src_pct + tgt_pct) return CELL_TARGET;
		if (roll < src_pct + tgt_pct + 6) return CELL_VOID;
		return CELL_EMPTY;
	endfunction

	// Offer one cell after a random gap and hold it until accepted
	task automatic push_cell(input logic [1:0] code, input logic close);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cell_value <= code;
		last_cell <= close;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cells_sent++;
		if (close) grids_sent++;
	endtask

	task automatic send_list(input logic [1:0] cells [$], input logic close);
		int i;
		for (i = 0; i < cells.size(); i++)
			push_cell(cells[i], close && (i == cells.size() - 1));
	endtask

	task automatic send_random_grid(input int ncells, input int tgt_pct, input int src_pct);
		int i;
		for (i = 0; i < ncells; i++)
			push_cell(pick_cell(tgt_pct, src_pct), i == ncells - 1);
	endtask

	// Hold the sender until every predicted result is in, then let it settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input int rows, input int cols);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_data <= rows[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_COLUMN_COUNT;
		cfg_data <= cols[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [1:0] pattern [$];
		int rows;
		int cols;
		int area;
		int ncells;
		int roll;
		int phase;
		int goal;
		int i;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short grid at reset size, code three blocking the path
		pattern = '{CELL_SOURCE, CELL_TARGET, CELL_TARGET, CELL_EMPTY, CELL_VOID,
			CELL_TARGET};
		send_list(pattern, 1'b1);

		// Zero sizes act as one cell
		drain();
		set_size(0, 0);
		pattern = '{CELL_TARGET};
		send_list(pattern, 1'b1);
		pattern = '{CELL_SOURCE};
		send_list(pattern, 1'b1);

		// Oversize rows clamp to the maximum
		drain();
		set_size(127, 2);
		pattern = '{CELL_SOURCE, CELL_TARGET, CELL_TARGET, CELL_TARGET, CELL_EMPTY,
			CELL_TARGET};
		send_list(pattern, 1'b1);

		// Cells past rows*columns are ignored by the search
		drain();
		set_size(2, 3);
		pattern = '{CELL_TARGET, CELL_TARGET, CELL_SOURCE, CELL_VOID, CELL_TARGET,
			CELL_EMPTY, CELL_TARGET, CELL_TARGET};
		send_list(pattern, 1'b1);

		// Resize in the middle of a load, with the sender held until results drain
		drain();
		set_size(1, 2);
		pattern = '{CELL_SOURCE};
		send_list(pattern, 1'b1);
		pattern = '{CELL_SOURCE, CELL_TARGET, CELL_TARGET};
		send_list(pattern, 1'b0);
		drain();
		set_size(2, 2);
		push_cell(CELL_TARGET, 1'b1);

		// Single row and single column at full length
		drain();
		set_size(1, 64);
		for (i = 0; i < MAX_SIDE; i++)
			push_cell((i == 0) ? CELL_SOURCE : CELL_TARGET, i == MAX_SIDE - 1);
		drain();
		set_size(64, 1);
		for (i = 0; i < MAX_SIDE; i++)
			push_cell((i == MAX_SIDE - 1) ? CELL_SOURCE : CELL_TARGET, i == MAX_SIDE - 1);

		// Random grids under each idle and stall mix
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle = 0;
					sink_stall = 0;
				end
				1: begin
					src_idle = 54;
					sink_stall = 0;
				end
				2: begin
					src_idle = 0;
					sink_stall = 54;
				end
				default: begin
					src_idle = 10;
					sink_stall = 10;
				end
			endcase
			goal = cells_sent + RANDOM_CELLS / 4;
			while (cells_sent < goal) begin
				drain();
				rows = pick_side();
				cols = pick_side();
				if (eff_side(rows) * eff_side(cols) > MAX_RANDOM_AREA)
					cols = $urandom_range(8, 1);
				set_size(rows, cols);
				area = eff_side(rows) * eff_side(cols);
				// mostly exact grids, some short and some long ones
				repeat ($urandom_range(4, 1)) begin
					roll = $urandom_range(99);
					if (roll < 80) ncells = area;
					else if (roll < 90) ncells = $urandom_range(area, 1);
					else ncells = area + $urandom_range(5, 1);
					send_random_grid(ncells, $urandom_range(75, 20), $urandom_range(15, 0));
				end
			end
		end

		drain();
		$display("Summary: %0d cells in %0d grids, %0d results compared, %0d unreachable,",
			cells_sent, grids_sent, results_checked, unreach_seen);
		$display("         sides 1 to 64 with zero, oversize, short, long and resized loads");
		if (fail_count == 0 && open_results == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
